// ===== rtl/srarq_pkg.sv =====
package srarq_pkg;

  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;
  localparam int BUF_BITS     = SEQ_BITS - 1;
  localparam int NR_BUFS      = 2 ** BUF_BITS;

  localparam logic [SEQ_BITS-1:0] NR_BUFS_V = SEQ_BITS'(NR_BUFS);

  localparam logic [2:0] OP_PKT_READY = 3'd0;
  localparam logic [2:0] OP_FRAME_ARR = 3'd1;
  localparam logic [2:0] OP_CKSUM_ERR = 3'd2;
  localparam logic [2:0] OP_RETX_TMO  = 3'd3;
  localparam logic [2:0] OP_ACK_TMO   = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_ACK_TMR = 3'd3;
  localparam logic [2:0] ACT_DONE    = 3'd4;

  localparam logic [1:0] ATC_NONE  = 2'd0;
  localparam logic [1:0] ATC_START = 2'd1;
  localparam logic [1:0] ATC_STOP  = 2'd2;

  typedef struct packed {
    logic [2:0]              operation;
    logic [PAYLOAD_BITS-1:0] new_packet;
    logic [1:0]              rx_kind;
    logic [SEQ_BITS-1:0]     rx_seq;
    logic [SEQ_BITS-1:0]     rx_ack;
    logic [PAYLOAD_BITS-1:0] rx_payload;
    logic [SEQ_BITS-1:0]     timeout_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              action;
    logic [1:0]              tx_kind;
    logic [SEQ_BITS-1:0]     tx_seq;
    logic [SEQ_BITS-1:0]     tx_ack;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [BUF_BITS-1:0]     timer_index;
    logic                    start_retx_timer;
    logic [1:0]              ack_timer_cmd;
    logic                    network_enable;
    logic                    rejected;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic                    snd_we;
    logic [BUF_BITS-1:0]     snd_waddr;
    logic [PAYLOAD_BITS-1:0] snd_wdata;
    logic [BUF_BITS-1:0]     snd_raddr;
    logic                    rcv_we;
    logic [BUF_BITS-1:0]     rcv_waddr;
    logic [PAYLOAD_BITS-1:0] rcv_wdata;
    logic [BUF_BITS-1:0]     rcv_raddr;
    logic                    rcv_take;
  } buf_ctl_t;

  function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b,
                                     input logic [SEQ_BITS-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

// ===== rtl/srarq_bufs.sv =====
module srarq_bufs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srarq_pkg::buf_ctl_t                 ctl,
  output logic [srarq_pkg::PAYLOAD_BITS-1:0]  snd_rdata,
  output logic [srarq_pkg::PAYLOAD_BITS-1:0]  rcv_rdata,
  output logic [srarq_pkg::NR_BUFS-1:0]       marks
);

  logic [srarq_pkg::PAYLOAD_BITS-1:0] snd_mem_r [srarq_pkg::NR_BUFS];
  logic [srarq_pkg::PAYLOAD_BITS-1:0] rcv_mem_r [srarq_pkg::NR_BUFS];
  logic [srarq_pkg::NR_BUFS-1:0]      marks_r;
  logic [srarq_pkg::NR_BUFS-1:0]      marks_nxt;

  always_comb begin
    marks_nxt = marks_r;
    if (ctl.rcv_we) begin
      marks_nxt[ctl.rcv_waddr] = 1'b1;
    end
    if (ctl.rcv_take) begin
      marks_nxt[ctl.rcv_raddr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
    end else begin
      marks_r <= marks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.snd_we) begin
      snd_mem_r[ctl.snd_waddr] <= ctl.snd_wdata;
    end
    if (ctl.rcv_we) begin
      rcv_mem_r[ctl.rcv_waddr] <= ctl.rcv_wdata;
    end
  end

  assign snd_rdata = snd_mem_r[ctl.snd_raddr];
  assign rcv_rdata = rcv_mem_r[ctl.rcv_raddr];
  assign marks     = marks_r;

endmodule

// ===== rtl/srarq_ctrl.sv =====
module srarq_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  srarq_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output srarq_pkg::out_item_t               out_data,
  output srarq_pkg::buf_ctl_t                bctl,
  input  logic [srarq_pkg::PAYLOAD_BITS-1:0] snd_rdata,
  input  logic [srarq_pkg::PAYLOAD_BITS-1:0] rcv_rdata,
  input  logic [srarq_pkg::NR_BUFS-1:0]      marks
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT,
    ST_DELIVER,
    ST_RELEASE,
    ST_ACKT,
    ST_DONE
  } state_t;

  localparam int SB = srarq_pkg::SEQ_BITS;
  localparam int BB = srarq_pkg::BUF_BITS;

  state_t               state_r, state_nxt;
  srarq_pkg::in_item_t  item_r, item_nxt;
  logic [SB-1:0]        ale_r, ale_nxt;
  logic [SB-1:0]        nss_r, nss_nxt;
  logic [SB-1:0]        exp_r, exp_nxt;
  logic [SB-1:0]        rue_r, rue_nxt;
  logic [SB-1:0]        outst_r, outst_nxt;
  logic                 nak_ok_r, nak_ok_nxt;
  logic                 start_ack_r, start_ack_nxt;
  logic                 rej_r, rej_nxt;
  logic                 out_valid_r, out_valid_nxt;
  srarq_pkg::out_item_t out_data_r, out_data_nxt;

  srarq_pkg::out_item_t oi;
  logic                 emit;
  logic                 emit_ok;
  logic [SB-1:0]        win_a, win_b, win_c;
  logic                 win_hit;
  logic [SB-1:0]        piggy;
  logic [SB-1:0]        want;

  assign emit_ok = !out_valid_r || !out_stall;
  assign piggy   = exp_r - SB'(1);
  assign want    = item_r.rx_ack + SB'(1);
  assign win_hit = srarq_pkg::in_window(win_a, win_b, win_c);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ale_nxt       = ale_r;
    nss_nxt       = nss_r;
    exp_nxt       = exp_r;
    rue_nxt       = rue_r;
    outst_nxt     = outst_r;
    nak_ok_nxt    = nak_ok_r;
    start_ack_nxt = start_ack_r;
    rej_nxt       = rej_r;
    emit          = 1'b0;
    oi            = '0;
    bctl          = '0;
    bctl.snd_wdata = item_r.new_packet;
    bctl.rcv_wdata = item_r.rx_payload;
    bctl.rcv_waddr = item_r.rx_seq[BB-1:0];
    bctl.rcv_raddr = exp_r[BB-1:0];
    bctl.snd_raddr = item_r.timeout_seq[BB-1:0];
    win_a         = ale_r;
    win_b         = item_r.rx_ack;
    win_c         = nss_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_data;
          start_ack_nxt = 1'b0;
          rej_nxt       = 1'b0;
          state_nxt     = ST_FRONT;
        end
      end
      ST_FRONT: begin
        if (item_r.operation == srarq_pkg::OP_FRAME_ARR &&
            item_r.rx_kind == srarq_pkg::KIND_DATA) begin
          win_a = exp_r;
          win_b = item_r.rx_seq;
          win_c = rue_r;
        end else if (item_r.operation == srarq_pkg::OP_FRAME_ARR) begin
          win_b = want;
          bctl.snd_raddr = want[BB-1:0];
        end
        if (emit_ok) begin
          oi.action        = srarq_pkg::ACT_SEND;
          oi.tx_ack        = piggy;
          oi.ack_timer_cmd = srarq_pkg::ATC_STOP;
          state_nxt        = ST_DONE;
          unique case (item_r.operation)
            srarq_pkg::OP_PKT_READY: begin
              if (outst_r == srarq_pkg::NR_BUFS_V) begin
                rej_nxt = 1'b1;
              end else begin
                emit                = 1'b1;
                oi.tx_kind          = srarq_pkg::KIND_DATA;
                oi.tx_seq           = nss_r;
                oi.payload          = item_r.new_packet;
                oi.timer_index      = nss_r[BB-1:0];
                oi.start_retx_timer = 1'b1;
                bctl.snd_we         = 1'b1;
                bctl.snd_waddr      = nss_r[BB-1:0];
                outst_nxt           = outst_r + SB'(1);
                nss_nxt             = nss_r + SB'(1);
              end
            end
            srarq_pkg::OP_FRAME_ARR: begin
              if (item_r.rx_kind == srarq_pkg::KIND_DATA) begin
                if (item_r.rx_seq != exp_r && nak_ok_r) begin
                  emit       = 1'b1;
                  oi.tx_kind = srarq_pkg::KIND_NAK;
                  oi.tx_seq  = '1;
                  nak_ok_nxt = 1'b0;
                end else begin
                  start_ack_nxt = 1'b1;
                end
                if (win_hit && !marks[item_r.rx_seq[BB-1:0]]) begin
                  bctl.rcv_we = 1'b1;
                end
                state_nxt = ST_DELIVER;
              end else begin
                if (item_r.rx_kind == srarq_pkg::KIND_NAK && win_hit) begin
                  emit                = 1'b1;
                  oi.tx_kind          = srarq_pkg::KIND_DATA;
                  oi.tx_seq           = want;
                  oi.payload          = snd_rdata;
                  oi.timer_index      = want[BB-1:0];
                  oi.start_retx_timer = 1'b1;
                end
                state_nxt = ST_RELEASE;
              end
            end
            srarq_pkg::OP_CKSUM_ERR: begin
              if (nak_ok_r) begin
                emit       = 1'b1;
                oi.tx_kind = srarq_pkg::KIND_NAK;
                oi.tx_seq  = '1;
                nak_ok_nxt = 1'b0;
              end
            end
            srarq_pkg::OP_RETX_TMO: begin
              emit                = 1'b1;
              oi.tx_kind          = srarq_pkg::KIND_DATA;
              oi.tx_seq           = item_r.timeout_seq;
              oi.payload          = snd_rdata;
              oi.timer_index      = item_r.timeout_seq[BB-1:0];
              oi.start_retx_timer = 1'b1;
            end
            srarq_pkg::OP_ACK_TMO: begin
              emit       = 1'b1;
              oi.tx_kind = srarq_pkg::KIND_ACK;
              oi.tx_seq  = '1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DELIVER: begin
        if (marks[exp_r[BB-1:0]]) begin
          if (emit_ok) begin
            emit          = 1'b1;
            oi.action     = srarq_pkg::ACT_DELIVER;
            oi.payload    = rcv_rdata;
            bctl.rcv_take = 1'b1;
            nak_ok_nxt    = 1'b1;
            exp_nxt       = exp_r + SB'(1);
            rue_nxt       = rue_r + SB'(1);
            start_ack_nxt = 1'b1;
          end
        end else begin
          state_nxt = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (win_hit) begin
          if (emit_ok) begin
            emit           = 1'b1;
            oi.action      = srarq_pkg::ACT_STOP;
            oi.timer_index = ale_r[BB-1:0];
            outst_nxt      = outst_r - SB'(1);
            ale_nxt        = ale_r + SB'(1);
          end
        end else begin
          state_nxt = start_ack_r ? ST_ACKT : ST_DONE;
        end
      end
      ST_ACKT: begin
        if (emit_ok) begin
          emit             = 1'b1;
          oi.action        = srarq_pkg::ACT_ACK_TMR;
          oi.ack_timer_cmd = srarq_pkg::ATC_START;
          state_nxt        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (emit_ok) begin
          emit              = 1'b1;
          oi.action         = srarq_pkg::ACT_DONE;
          oi.network_enable = outst_r < srarq_pkg::NR_BUFS_V;
          oi.rejected       = rej_r;
          oi.last           = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
    out_data_nxt  = emit ? oi : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ale_r       <= '0;
      nss_r       <= '0;
      exp_r       <= '0;
      rue_r       <= srarq_pkg::NR_BUFS_V;
      outst_r     <= '0;
      nak_ok_r    <= 1'b1;
      start_ack_r <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ale_r       <= ale_nxt;
      nss_r       <= nss_nxt;
      exp_r       <= exp_nxt;
      rue_r       <= rue_nxt;
      outst_r     <= outst_nxt;
      nak_ok_r    <= nak_ok_nxt;
      start_ack_r <= start_ack_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/selective_repeat_arq_controller_unit.sv =====
// Selective-repeat ARQ link controller with 3-bit sequence numbers and
// send and receive windows of four frames.
// The input channel (in_valid, in_stall, in_data) carries one link event per
// transaction: packet ready, frame arrival, checksum error, retransmit
// timeout or ack timeout.
// The result channel (out_valid, out_stall, out_data) returns the items that
// the event causes, one per transaction: any frame to send, in-order
// deliveries, retransmit-timer stops, at most one ack-timer start, and a closing
// status item with last set.
// The sequencer handles one event at a time and emits at most one item per
// cycle through a single output register; the time from acceptance to the
// status item grows with the number of deliveries and released frames that
// the event causes.
// in_stall is high from the transaction until the status item is loaded.
// When the receiver stalls, the output register holds its item and the
// sequencer waits in place without losing or repeating anything.
// After reset both windows are empty, the ack lower edge, next send sequence
// and expected sequence are zero, and the block is ready for an event.
module selective_repeat_arq_controller_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srarq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srarq_pkg::out_item_t out_data
);

  srarq_pkg::buf_ctl_t                bctl;
  logic [srarq_pkg::PAYLOAD_BITS-1:0] snd_rdata;
  logic [srarq_pkg::PAYLOAD_BITS-1:0] rcv_rdata;
  logic [srarq_pkg::NR_BUFS-1:0]      marks;

  srarq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bctl      (bctl),
    .snd_rdata (snd_rdata),
    .rcv_rdata (rcv_rdata),
    .marks     (marks)
  );

  srarq_bufs u_bufs (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (bctl),
    .snd_rdata (snd_rdata),
    .rcv_rdata (rcv_rdata),
    .marks     (marks)
  );

endmodule

// ===== tb/sv/srarq_link_checker.sv =====
module srarq_link_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  srarq_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  srarq_pkg::out_item_t out_data,
  output int                   mismatch_count,
  output int                   results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import srarq_pkg::*;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [BUF_BITS-1:0]     slot_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  seq_t  snd_base;
  seq_t  snd_next;
  seq_t  rcv_next;
  seq_t  rcv_limit;
  seq_t  in_flight;
  logic  nak_ok;
  logic  rcv_have [NR_BUFS];
  word_t snd_store [NR_BUFS];
  word_t rcv_store [NR_BUFS];

  out_item_t link_actions_q [$];
  int        fails = 0;
  int        waiting = 0;
  int        results_seen = 0;

  assign mismatch_count  = fails;
  assign results_waiting = waiting;

  function automatic logic seq_between(seq_t lo, seq_t x, seq_t hi);
    seq_t off;
    seq_t span;
    off  = x - lo;
    span = hi - lo;
    return off < span;
  endfunction

  function automatic void queue_result(logic [2:0] action, logic [1:0] kind, seq_t seq,
                                       word_t pay, slot_t tidx, logic retx,
                                       logic [1:0] atc);
    out_item_t r;
    r = '0;
    r.action           = action;
    r.tx_kind          = kind;
    r.tx_seq           = seq;
    r.tx_ack           = (action == ACT_SEND) ? seq_t'(rcv_next - 1'b1) : '0;
    r.payload          = pay;
    r.timer_index      = tidx;
    r.start_retx_timer = retx;
    r.ack_timer_cmd    = atc;
    link_actions_q.push_back(r);
  endfunction

  function automatic void send_data_frame(seq_t seq);
    queue_result(ACT_SEND, KIND_DATA, seq, snd_store[seq[BUF_BITS-1:0]],
                 seq[BUF_BITS-1:0], 1'b1, ATC_STOP);
  endfunction

  function automatic void send_control_frame(logic [1:0] kind);
    queue_result(ACT_SEND, kind, '1, '0, '0, 1'b0, ATC_STOP);
    if (kind == KIND_NAK) nak_ok = 1'b0;
  endfunction

  function automatic void clear_link_state();
    snd_base  = '0;
    snd_next  = '0;
    rcv_next  = '0;
    rcv_limit = NR_BUFS_V;
    in_flight = '0;
    nak_ok    = 1'b1;
    foreach (rcv_have[i]) begin
      rcv_have[i]  = 1'b0;
      snd_store[i] = '0;
      rcv_store[i] = '0;
    end
    link_actions_q.delete();
  endfunction

  function automatic void predict_event(in_item_t ev);
    logic      refused;
    logic      ack_pending;
    slot_t     s;
    out_item_t fin;
    refused     = 1'b0;
    ack_pending = 1'b0;
    case (ev.operation)
      OP_PKT_READY: begin
        if (in_flight >= NR_BUFS_V) begin
          refused = 1'b1;
        end else begin
          in_flight = in_flight + 1'b1;
          snd_store[snd_next[BUF_BITS-1:0]] = ev.new_packet;
          send_data_frame(snd_next);
          snd_next = snd_next + 1'b1;
        end
      end
      OP_FRAME_ARR: begin
        if (ev.rx_kind == KIND_DATA) begin
          if (ev.rx_seq != rcv_next && nak_ok) send_control_frame(KIND_NAK);
          else ack_pending = 1'b1;
          s = ev.rx_seq[BUF_BITS-1:0];
          if (seq_between(rcv_next, ev.rx_seq, rcv_limit) && !rcv_have[s]) begin
            rcv_have[s]  = 1'b1;
            rcv_store[s] = ev.rx_payload;
            while (rcv_have[rcv_next[BUF_BITS-1:0]]) begin
              queue_result(ACT_DELIVER, KIND_DATA, '0, rcv_store[rcv_next[BUF_BITS-1:0]],
                           '0, 1'b0, ATC_NONE);
              nak_ok = 1'b1;
              rcv_have[rcv_next[BUF_BITS-1:0]] = 1'b0;
              rcv_next    = rcv_next + 1'b1;
              rcv_limit   = rcv_limit + 1'b1;
              ack_pending = 1'b1;
            end
          end
        end
        if (ev.rx_kind == KIND_NAK && seq_between(snd_base, seq_t'(ev.rx_ack + 1'b1), snd_next))
          send_data_frame(seq_t'(ev.rx_ack + 1'b1));
        while (seq_between(snd_base, ev.rx_ack, snd_next)) begin
          in_flight = in_flight - 1'b1;
          queue_result(ACT_STOP, KIND_DATA, '0, '0, snd_base[BUF_BITS-1:0], 1'b0, ATC_NONE);
          snd_base = snd_base + 1'b1;
        end
      end
      OP_CKSUM_ERR: begin
        if (nak_ok) send_control_frame(KIND_NAK);
      end
      OP_RETX_TMO: begin
        send_data_frame(ev.timeout_seq);
      end
      OP_ACK_TMO: begin
        send_control_frame(KIND_ACK);
      end
      default: begin
      end
    endcase
    if (ack_pending) queue_result(ACT_ACK_TMR, KIND_DATA, '0, '0, '0, 1'b0, ATC_START);
    fin = '0;
    fin.action         = ACT_DONE;
    fin.network_enable = (in_flight < NR_BUFS_V);
    fin.rejected       = refused;
    fin.last           = 1'b1;
    link_actions_q.push_back(fin);
  endfunction

  task automatic report_mismatch(string msg);
    fails++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, word_t got, word_t want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s is %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (link_actions_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
    end else begin
      want = link_actions_q.pop_front();
      check_field("action", word_t'(got.action), word_t'(want.action));
      check_field("tx_kind", word_t'(got.tx_kind), word_t'(want.tx_kind));
      check_field("tx_seq", word_t'(got.tx_seq), word_t'(want.tx_seq));
      check_field("tx_ack", word_t'(got.tx_ack), word_t'(want.tx_ack));
      check_field("payload", got.payload, want.payload);
      check_field("timer_index", word_t'(got.timer_index), word_t'(want.timer_index));
      check_field("start_retx_timer", word_t'(got.start_retx_timer),
                  word_t'(want.start_retx_timer));
      check_field("ack_timer_cmd", word_t'(got.ack_timer_cmd), word_t'(want.ack_timer_cmd));
      check_field("network_enable", word_t'(got.network_enable),
                  word_t'(want.network_enable));
      check_field("rejected", word_t'(got.rejected), word_t'(want.rejected));
      check_field("last", word_t'(got.last), word_t'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_link_state();
    end else begin
      if (in_valid && !in_stall) predict_event(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    waiting <= link_actions_q.size();
  end

endmodule

// ===== tb/sv/selective_repeat_arq_controller_unit_test.sv =====
module selective_repeat_arq_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srarq_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_EVENTS    = 200;
  localparam int IDLE_PCT         = 23;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SEQ_MAX          = (2 ** SEQ_BITS) - 1;

  typedef logic [SEQ_BITS-1:0]     seq_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        mismatch_count;
  int        results_waiting;

  bit gaps_on = 1'b1;
  int hold_requests = 0;
  int holds_done = 0;

  // Window bookkeeping on the stimulus side, used only to shape well-formed traffic.
  seq_t tx_edge = '0;
  seq_t tx_next = '0;
  int   tx_out = 0;
  seq_t rx_base = '0;
  bit   rx_mark [NR_BUFS];
  bit   slot_written [NR_BUFS];

  always #10 clk = ~clk;

  selective_repeat_arq_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  srarq_link_checker link_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting)
  );

  function automatic void track_event(in_item_t ev);
    seq_t off;
    if (ev.operation == OP_PKT_READY && tx_out < NR_BUFS) begin
      slot_written[tx_next[BUF_BITS-1:0]] = 1'b1;
      tx_next = tx_next + 1'b1;
      tx_out++;
    end else if (ev.operation == OP_FRAME_ARR) begin
      if (ev.rx_kind == KIND_DATA) begin
        off = ev.rx_seq - rx_base;
        if (off < NR_BUFS) rx_mark[ev.rx_seq[BUF_BITS-1:0]] = 1'b1;
        while (rx_mark[rx_base[BUF_BITS-1:0]]) begin
          rx_mark[rx_base[BUF_BITS-1:0]] = 1'b0;
          rx_base = rx_base + 1'b1;
        end
      end
      off = ev.rx_ack - tx_edge;
      if (off < tx_out) begin
        tx_out  = tx_out - off - 1;
        tx_edge = ev.rx_ack + 1'b1;
      end
    end
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation   = 3'($urandom_range(OP_SPARE_7));
    it.new_packet  = word_t'($urandom);
    it.rx_kind     = 2'($urandom_range(KIND_SPARE));
    it.rx_seq      = seq_t'($urandom_range(SEQ_MAX));
    it.rx_ack      = seq_t'($urandom_range(SEQ_MAX));
    it.rx_payload  = word_t'($urandom);
    it.timeout_seq = seq_t'($urandom_range(SEQ_MAX));
    return it;
  endfunction

  function automatic in_item_t event_item(logic [2:0] op, logic [1:0] kind, seq_t seq,
                                          seq_t ack, word_t pay);
    in_item_t it;
    it = rand_item();
    it.operation   = op;
    it.rx_kind     = kind;
    it.rx_seq      = seq;
    it.rx_ack      = ack;
    it.timeout_seq = seq;
    it.new_packet  = pay;
    it.rx_payload  = pay;
    return it;
  endfunction

  function automatic seq_t ack_choice();
    int sel;
    sel = $urandom_range(9);
    if (tx_out > 0 && sel < 5) return tx_edge + seq_t'($urandom_range(tx_out - 1));
    if (sel < 9) return tx_edge - 1'b1;
    return seq_t'($urandom_range(SEQ_MAX));
  endfunction

  function automatic seq_t written_seq();
    seq_t s;
    do s = seq_t'($urandom_range(SEQ_MAX)); while (!slot_written[s[BUF_BITS-1:0]]);
    return s;
  endfunction

  function automatic in_item_t next_random_event();
    in_item_t it;
    int       r;
    int       k;
    it = rand_item();
    r  = $urandom_range(99);
    if (r < 8) begin
    end else if (r < 36) begin
      if (tx_out >= NR_BUFS && $urandom_range(3) != 0) begin
        it.operation = OP_FRAME_ARR;
        it.rx_kind   = KIND_ACK;
        it.rx_ack    = ack_choice();
      end else begin
        it.operation = OP_PKT_READY;
      end
    end else if (r < 66) begin
      k = ($urandom_range(1) == 0) ? 0 : $urandom_range(NR_BUFS - 1, 1);
      if ($urandom_range(19) == 0) k = $urandom_range(SEQ_MAX);
      it.operation = OP_FRAME_ARR;
      it.rx_kind   = KIND_DATA;
      it.rx_seq    = rx_base + seq_t'(k);
      it.rx_ack    = ack_choice();
    end else if (r < 78) begin
      it.operation = OP_FRAME_ARR;
      it.rx_kind   = ($urandom_range(9) == 0) ? KIND_SPARE : KIND_ACK;
      it.rx_ack    = ack_choice();
    end else if (r < 85) begin
      it.operation = OP_FRAME_ARR;
      it.rx_kind   = KIND_NAK;
      if (tx_out > 0 && $urandom_range(3) != 0)
        it.rx_ack = tx_edge - 1'b1 + seq_t'($urandom_range(tx_out - 1));
    end else if (r < 90) begin
      it.operation = OP_CKSUM_ERR;
    end else if (r < 95) begin
      it.operation = OP_RETX_TMO;
      if (tx_out > 0 && $urandom_range(1) == 0)
        it.timeout_seq = tx_edge + seq_t'($urandom_range(tx_out - 1));
    end else begin
      it.operation = OP_ACK_TMO;
    end
    // A retransmit timeout may only name a send slot that already holds a packet.
    if (it.operation == OP_RETX_TMO) begin
      if (!slot_written[0]) it.operation = OP_ACK_TMO;
      else if (!slot_written[it.timeout_seq[BUF_BITS-1:0]]) it.timeout_seq = written_seq();
    end
    return it;
  endfunction

  task automatic offer(in_item_t it);
    track_event(it);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        repeat (LONG_HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    in_item_t directed_q [$];
    int       n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_q.push_back(event_item(OP_ACK_TMO, KIND_DATA, 3'd0, 3'd0, 32'h0));
    directed_q.push_back(event_item(OP_CKSUM_ERR, KIND_DATA, 3'd0, 3'd0, 32'h0));
    directed_q.push_back(event_item(OP_CKSUM_ERR, KIND_DATA, 3'd0, 3'd0, 32'h0));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, 32'h0000_0000));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, 32'hFFFF_FFFF));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_RETX_TMO, KIND_DATA, 3'd1, 3'd0, 32'h0));
    directed_q.push_back(event_item(OP_RETX_TMO, KIND_DATA, 3'd7, 3'd0, 32'h0));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd1, 3'd7, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd2, 3'd7, 32'hFFFF_FFFF));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd3, 3'd7, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd2, 3'd7, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd6, 3'd7, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd0, 3'd3, 32'h0000_0000));
    directed_q.push_back(event_item(OP_PKT_READY, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_NAK, 3'd0, 3'd3, 32'h0));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_NAK, 3'd0, 3'd5, 32'h0));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_SPARE, 3'd0, 3'd4, 32'h0));
    directed_q.push_back(event_item(OP_SPARE_5, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_SPARE_6, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_SPARE_7, KIND_DATA, 3'd0, 3'd0, $urandom));
    directed_q.push_back(event_item(OP_FRAME_ARR, KIND_DATA, 3'd5, 3'd4, $urandom));
    foreach (directed_q[i]) offer(directed_q[i]);
    drain_results();

    for (n = 0; n < RANDOM_EVENTS; n++) begin
      gaps_on = !(n >= 100 && n < 150);
      if (n == 60) hold_requests++;
      if (n % 50 == 49) drain_results();
      offer(next_random_event());
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srarq_pkg.sv
rtl/srarq_bufs.sv
rtl/srarq_ctrl.sv
rtl/selective_repeat_arq_controller_unit.sv
tb/sv/srarq_link_checker.sv
tb/sv/selective_repeat_arq_controller_unit_test.sv
